// ===== rtl/chc_pkg.sv =====
// Shared constants, types and the quarter-wave sine table for the Cubehelix pixel color block.
package chc_pkg;

    // Angle resolution of the phase index and segment size
    localparam int ANGLE_TABLE_BITS = 10;
    localparam int MAX_PIXELS       = 1024;

    // Quarter-wave table geometry
    localparam int QBITS      = ANGLE_TABLE_BITS - 2;
    localparam int QTAB_DEPTH = 1 << QBITS;

    // Pipeline depth shared by both datapaths
    localparam int STAGES = 5;

    // Fixed-point constants
    localparam logic [15:0] THIRD_TURN      = 16'd21845;
    localparam logic [15:0] ONE_Q15         = 16'd32768;
    localparam logic [10:0] STRIP_LEN_RESET = 11'(MAX_PIXELS);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_START_OFFSET = 1'b0,
        CFG_STRIP_LENGTH = 1'b1
    } cfg_reg_t;

    // Cubehelix coefficients, signed Q15, channel order red, green, blue
    localparam logic signed [17:0] COEF_COS [3] = '{-18'sd4870, -18'sd9577, 18'sd64649};
    localparam logic signed [17:0] COEF_SIN [3] = '{18'sd58418, -18'sd29704, 18'sd0};

    // Per-stage load strobes handed to the datapaths
    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctl_t;

    typedef logic [15:0] qsin_table_t [QTAB_DEPTH];

    // Polynomial quarter sine at table point k, Q15 in 0..32768
    function automatic logic [15:0] qsin_val(int unsigned k);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned acc;
        longint unsigned s16;
        longint unsigned s15;
        u   = 64'(k) << (16 - QBITS);
        u2  = (u * u) >> 16;
        acc = 64'd5223 - ((64'd307 * u2) >> 16);
        acc = 64'd42334 - ((acc * u2) >> 16);
        acc = 64'd102944 - ((acc * u2) >> 16);
        s16 = (acc * u) >> 16;
        s15 = (s16 + 64'd1) >> 1;
        if (s15 > 64'd32768)
        begin
            s15 = 64'd32768;
        end
        return s15[15:0];
    endfunction

    function automatic qsin_table_t build_qsin_table();
        qsin_table_t t;
        for (int k = 0; k < QTAB_DEPTH; k++)
        begin
            t[k] = qsin_val(k);
        end
        return t;
    endfunction

    // Points 0 .. QTAB_DEPTH-1 in the table, the quarter-turn point on its own
    localparam qsin_table_t QSIN_TABLE = build_qsin_table();
    localparam logic [15:0] QSIN_FULL  = qsin_val(QTAB_DEPTH);

endpackage

// ===== rtl/chc_addr_pipe.sv =====
// Pipelined index wrap (remainder by the segment length) and address offset.
module chc_addr_pipe (
    input  logic               clk,
    input  chc_pkg::pipe_ctl_t ctl,
    input  logic [15:0]        pixel_index,
    input  logic [9:0]         start_offset,
    input  logic [10:0]        strip_length,
    output logic [10:0]        pixel_address
);
    import chc_pkg::*;

    // Four restoring remainder steps, one dividend bit each
    function automatic logic [10:0] mod_step(logic [10:0] rem, logic [3:0] bits,
                                             logic [10:0] d);
        logic [11:0] r;
        logic [10:0] acc;
        acc = rem;
        for (int i = 3; i >= 0; i--)
        begin
            r = {acc, bits[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
            end
            acc = r[10:0];
        end
        return acc;
    endfunction

    logic [10:0] rem_reg  [4];
    logic [10:0] rem_next [4];
    logic [11:0] rest_reg  [3];
    logic [11:0] rest_next [3];
    logic [10:0] addr_reg;
    logic [10:0] addr_next;

    // Remainder stages: top four bits first
    always_comb
    begin
        rem_next[0]  = mod_step(11'd0, pixel_index[15:12], strip_length);
        rest_next[0] = pixel_index[11:0];
        rem_next[1]  = mod_step(rem_reg[0], rest_reg[0][11:8], strip_length);
        rest_next[1] = {rest_reg[0][7:0], 4'd0};
        rem_next[2]  = mod_step(rem_reg[1], rest_reg[1][11:8], strip_length);
        rest_next[2] = {rest_reg[1][7:0], 4'd0};
        rem_next[3]  = mod_step(rem_reg[2], rest_reg[2][11:8], strip_length);
    end

    // Zero length wraps to zero; the sum wraps modulo 2048
    always_comb
    begin
        if (strip_length == 11'd0)
        begin
            addr_next = {1'b0, start_offset};
        end
        else
        begin
            addr_next = rem_reg[3] + {1'b0, start_offset};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            rem_reg[0]  <= rem_next[0];
            rest_reg[0] <= rest_next[0];
        end
        if (ctl.load[1])
        begin
            rem_reg[1]  <= rem_next[1];
            rest_reg[1] <= rest_next[1];
        end
        if (ctl.load[2])
        begin
            rem_reg[2]  <= rem_next[2];
            rest_reg[2] <= rest_next[2];
        end
        if (ctl.load[3])
        begin
            rem_reg[3] <= rem_next[3];
        end
        if (ctl.load[4])
        begin
            addr_reg <= addr_next;
        end
    end

    assign pixel_address = addr_reg;

endmodule

// ===== rtl/chc_color_pipe.sv =====
// Five-stage Cubehelix color datapath: sine lookup, amplitude, mixing, clamping.
module chc_color_pipe (
    input  logic               clk,
    input  chc_pkg::pipe_ctl_t ctl,
    input  logic [15:0]        hue,
    input  logic [15:0]        saturation,
    input  logic [15:0]        lightness,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);
    import chc_pkg::*;

    // Full-wave sine from the quarter table, signed Q15
    function automatic logic signed [16:0] table_sine(logic [ANGLE_TABLE_BITS-1:0] idx);
        logic [1:0]       quad;
        logic [QBITS-1:0] frac;
        logic [QBITS-1:0] mirror;
        logic [15:0]      mag;
        logic signed [16:0] v;
        quad   = idx[ANGLE_TABLE_BITS-1 -: 2];
        frac   = idx[QBITS-1:0];
        mirror = ~frac + 1'b1;
        if (quad[0])
        begin
            if (frac == '0)
            begin
                mag = QSIN_FULL;
            end
            else
            begin
                mag = QSIN_TABLE[mirror];
            end
        end
        else
        begin
            mag = QSIN_TABLE[frac];
        end
        v = {1'b0, mag};
        return quad[1] ? -v : v;
    endfunction

    // Clamp to 0..1.0, scale to 8 bits, full scale saturates
    function automatic logic [7:0] chan_out(logic signed [19:0] v);
        logic [8:0] q;
        if (v < 0)
        begin
            q = 9'd0;
        end
        else if (v > 20'sd32768)
        begin
            q = 9'd256;
        end
        else
        begin
            q = v[15:7];
        end
        return (q > 9'd255) ? 8'd255 : q[7:0];
    endfunction

    // Stage 1
    logic [15:0]        lig1_reg, lig1_next;
    logic [15:0]        sat1_reg;
    logic [13:0]        lq1_reg, lq1_next;
    logic signed [16:0] sin1_reg, sin1_next;
    logic signed [16:0] cos1_reg, cos1_next;
    // Stage 2
    logic [15:0]        lig2_reg;
    logic [14:0]        amp2_reg, amp2_next;
    logic signed [31:0] pc2_reg [3];
    logic signed [31:0] pc2_next [3];
    logic signed [31:0] ps2_reg [3];
    logic signed [31:0] ps2_next [3];
    // Stage 3
    logic [15:0]        lig3_reg;
    logic [14:0]        amp3_reg;
    logic signed [32:0] lin3_reg [3];
    logic signed [32:0] lin3_next [3];
    // Stage 4
    logic [15:0]        lig4_reg;
    logic signed [18:0] sh4_reg [3];
    logic signed [18:0] sh4_next [3];
    // Stage 5
    logic [7:0]         rgb5_reg [3];
    logic [7:0]         rgb5_next [3];

    // Stage 1: clamp lightness, L*(1-L), phase lookup
    always_comb
    begin
        logic [15:0] phase;
        logic [ANGLE_TABLE_BITS-1:0] pidx;
        logic [31:0] lq_prod;
        lig1_next = (lightness > ONE_Q15) ? ONE_Q15 : lightness;
        lq_prod   = 32'(lig1_next) * 32'(ONE_Q15 - lig1_next);
        lq1_next  = lq_prod[28:15];
        phase     = hue + THIRD_TURN;
        pidx      = phase[15 -: ANGLE_TABLE_BITS];
        sin1_next = table_sine(pidx);
        cos1_next = table_sine(pidx + ANGLE_TABLE_BITS'(QTAB_DEPTH));
    end

    // Stage 2: amplitude and coefficient products
    always_comb
    begin
        logic [29:0] amp_prod;
        logic signed [34:0] pc;
        logic signed [34:0] ps;
        amp_prod  = 30'(sat1_reg) * 30'(lq1_reg);
        amp2_next = amp_prod[29:15];
        for (int ch = 0; ch < 3; ch++)
        begin
            pc = COEF_COS[ch] * cos1_reg;
            ps = COEF_SIN[ch] * sin1_reg;
            pc2_next[ch] = pc[31:0];
            ps2_next[ch] = ps[31:0];
        end
    end

    // Stage 3: linear mix
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            lin3_next[ch] = 33'(pc2_reg[ch]) + 33'(ps2_reg[ch]);
        end
    end

    // Stage 4: amplitude times mix, floored by 2^30
    always_comb
    begin
        logic signed [48:0] wide;
        for (int ch = 0; ch < 3; ch++)
        begin
            wide = $signed({1'b0, amp3_reg}) * lin3_reg[ch];
            sh4_next[ch] = wide[48:30];
        end
    end

    // Stage 5: add lightness, clamp and scale
    always_comb
    begin
        logic signed [19:0] v;
        for (int ch = 0; ch < 3; ch++)
        begin
            v = $signed({4'd0, lig4_reg}) + 20'(sh4_reg[ch]);
            rgb5_next[ch] = chan_out(v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            lig1_reg <= lig1_next;
            sat1_reg <= saturation;
            lq1_reg  <= lq1_next;
            sin1_reg <= sin1_next;
            cos1_reg <= cos1_next;
        end
        if (ctl.load[1])
        begin
            lig2_reg <= lig1_reg;
            amp2_reg <= amp2_next;
            pc2_reg  <= pc2_next;
            ps2_reg  <= ps2_next;
        end
        if (ctl.load[2])
        begin
            lig3_reg <= lig2_reg;
            amp3_reg <= amp2_reg;
            lin3_reg <= lin3_next;
        end
        if (ctl.load[3])
        begin
            lig4_reg <= lig3_reg;
            sh4_reg  <= sh4_next;
        end
        if (ctl.load[4])
        begin
            rgb5_reg <= rgb5_next;
        end
    end

    assign red   = rgb5_reg[0];
    assign green = rgb5_reg[1];
    assign blue  = rgb5_reg[2];

`ifndef SYNTH
    // Black and full white carry no chroma, whatever the hue and saturation
    a_black_is_black: assert property (@(posedge clk)
        (ctl.load[4] && lig4_reg == 16'd0) |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("zero lightness gave a nonzero channel");
    a_white_is_white: assert property (@(posedge clk)
        (ctl.load[4] && lig4_reg == ONE_Q15)
        |=> (red == 8'd255 && green == 8'd255 && blue == 8'd255))
        else $error("full lightness did not give full white");
`endif

endmodule

// ===== rtl/cubehelix_pixel_color_top.sv =====
// Top level of the Cubehelix pixel color converter: handshake, config registers, pipeline control.
//
// Usage:
//   Input channel (in_valid / in_stall) carries pixel_index, hue, saturation and
//   lightness; one transaction per pixel. Output channel (out_valid / out_stall)
//   returns pixel_address, red, green and blue, one transaction per input, in order.
//   Throughput is one pixel per cycle while out_stall is low. Each accepted pixel
//   reaches out_valid through five register stages, set by the index wrap, which
//   resolves four bits of the remainder per stage, and by the color chain of
//   table lookup, amplitude product, mixing, amplitude times mix and clamping.
//   A stalled output freezes only the stages behind it that are full; empty
//   stages keep filling, so in_stall rises only with all five stages occupied.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 start_offset,
//   1 strip_length); the user writes only while the block is idle; the block does not enforce it.
//   Reset (rst_n low, asynchronous) empties the pipeline and sets start_offset
//   to 0 and strip_length to 1024.
module cubehelix_pixel_color_top (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] pixel_index,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] lightness,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] pixel_address,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import chc_pkg::*;

    logic [9:0]        start_offset_reg;
    logic [10:0]       strip_length_reg;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] rdy;
    pipe_ctl_t         ctl;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= '0;
            strip_length_reg <= STRIP_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_OFFSET: start_offset_reg <= cfg_data[9:0];
                CFG_STRIP_LENGTH: strip_length_reg <= cfg_data;
                default:          start_offset_reg <= start_offset_reg;
            endcase
        end
    end

    // A stage can take new data when empty or when its contents move on
    always_comb
    begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    // Stage loads and valid propagation
    always_comb
    begin
        ctl.load[0]   = in_valid && rdy[0];
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            ctl.load[k]   = valid_reg[k-1] && rdy[k];
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[STAGES-1];

    chc_addr_pipe u_addr (
        .clk           (clk),
        .ctl           (ctl),
        .pixel_index   (pixel_index),
        .start_offset  (start_offset_reg),
        .strip_length  (strip_length_reg),
        .pixel_address (pixel_address)
    );

    chc_color_pipe u_color (
        .clk        (clk),
        .ctl        (ctl),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

`ifndef SYNTH
    // Input backpressure only with every stage full and the output held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with room in the pipeline");
    // A taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !valid_reg[STAGES-2]) |=> !out_valid)
        else $error("output transaction repeated");
`endif

endmodule

// ===== test/chc_pixel_checker.sv =====
// Checker for the Cubehelix pixel color block: watches both channels, predicts and compares.
module chc_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] pixel_index,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] lightness,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [10:0] pixel_address,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output int          pending,
    output int          failures
);
    import chc_pkg::*;

    localparam int  QUARTER_BITS = ANGLE_TABLE_BITS - 2;
    localparam int  FULL_SCALE   = 32768;
    localparam int  HUE_SHIFT    = 21845;

    // Cubehelix mixing weights, signed Q15
    localparam longint RED_COS   = -4870;
    localparam longint RED_SIN   = 58418;
    localparam longint GREEN_COS = -9577;
    localparam longint GREEN_SIN = -29704;
    localparam longint BLUE_COS  = 64649;
    localparam longint BLUE_SIN  = 0;

    typedef struct packed {
        logic [10:0] address;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_color_t;

    pixel_color_t expected_pixels [$];
    logic [9:0]   seg_offset;
    logic [10:0]  seg_length;

    // sin(pi/2 * u / 65536), Q15 in 0..32768
    function automatic int quarter_wave(longint unsigned u);
        longint unsigned u2;
        longint unsigned acc;
        longint unsigned s16;
        longint unsigned s15;
        u2  = (u * u) >> 16;
        acc = 64'd5223 - ((64'd307 * u2) >> 16);
        acc = 64'd42334 - ((acc * u2) >> 16);
        acc = 64'd102944 - ((acc * u2) >> 16);
        s16 = (acc * u) >> 16;
        s15 = (s16 + 64'd1) >> 1;
        if (s15 > 64'd32768)
        begin
            s15 = 64'd32768;
        end
        return int'(s15);
    endfunction

    // Signed Q15 sine of a phase index of ANGLE_TABLE_BITS bits
    function automatic longint phase_sine(longint unsigned raw_index);
        longint unsigned angle;
        longint unsigned quad;
        longint unsigned frac;
        longint unsigned t;
        longint          v;
        angle = raw_index & ((64'd1 << ANGLE_TABLE_BITS) - 64'd1);
        quad  = angle >> QUARTER_BITS;
        frac  = angle & ((64'd1 << QUARTER_BITS) - 64'd1);
        t     = frac << (16 - QUARTER_BITS);
        if (quad[0])
        begin
            v = quarter_wave(64'd65536 - t);
        end
        else
        begin
            v = quarter_wave(t);
        end
        return quad[1] ? -v : v;
    endfunction

    // One channel: L plus amplitude times the mixed cos/sin term, clamped and scaled to 8 bits
    function automatic logic [7:0] mix_channel(longint l, longint amp, longint wc, longint ws,
                                               longint c, longint s);
        longint v;
        v = l + ((amp * (wc * c + ws * s)) >>> 30);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > FULL_SCALE)
        begin
            v = FULL_SCALE;
        end
        v = v >>> 7;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // Expected result of one input transaction under the current segment setting
    function automatic pixel_color_t cubehelix_color(logic [15:0] idx, logic [15:0] h,
                                                     logic [15:0] sat, logic [15:0] lig,
                                                     logic [9:0] off, logic [10:0] len);
        pixel_color_t    px;
        longint unsigned wrapped;
        longint unsigned lit;
        longint unsigned phase;
        longint unsigned angle;
        longint unsigned lq;
        longint          amp;
        longint          c;
        longint          s;
        wrapped    = (len == 11'd0) ? 64'd0 : 64'(idx) % 64'(len);
        px.address = 11'(wrapped + 64'(off));
        lit   = (lig > 16'd32768) ? 64'd32768 : 64'(lig);
        phase = (64'(h) + 64'(HUE_SHIFT)) & 64'hFFFF;
        angle = phase >> (16 - ANGLE_TABLE_BITS);
        s     = phase_sine(angle);
        c     = phase_sine(angle + (64'd1 << QUARTER_BITS));
        lq    = (lit * (64'd32768 - lit)) >> 15;
        amp   = longint'((64'(sat) * lq) >> 15);
        px.red   = mix_channel(longint'(lit), amp, RED_COS, RED_SIN, c, s);
        px.green = mix_channel(longint'(lit), amp, GREEN_COS, GREEN_SIN, c, s);
        px.blue  = mix_channel(longint'(lit), amp, BLUE_COS, BLUE_SIN, c, s);
        return px;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            failures++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Track register writes, queue predictions, compare output transactions in order
    always @(posedge clk or negedge rst_n)
    begin
        pixel_color_t want;
        if (!rst_n)
        begin
            seg_offset = 10'd0;
            seg_length = 11'd1024;
            expected_pixels.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_reg_t'(cfg_index) == CFG_START_OFFSET)
                begin
                    seg_offset = cfg_data[9:0];
                end
                else
                begin
                    seg_length = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_pixels.push_back(cubehelix_color(pixel_index, hue, saturation,
                                                          lightness, seg_offset, seg_length));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    failures++;
                    $error("output transaction with no prediction waiting");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_address", want.address, pixel_address);
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ===== test/tb_cubehelix_pixel_color_top.sv =====
// Testbench top for the Cubehelix pixel color block: stimulus, flow control and verdict.
module tb_cubehelix_pixel_color_top;
    import chc_pkg::*;

    localparam int LATENCY        = STAGES;
    localparam int PHASE_ITEMS    = 200;
    localparam int PHASES         = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [0:0]  cfg_index   = CFG_START_OFFSET;
    logic [10:0] cfg_data    = 11'd0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [15:0] pixel_index = 16'd0;
    logic [15:0] hue         = 16'd0;
    logic [15:0] saturation  = 16'd0;
    logic [15:0] lightness   = 16'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [10:0] pixel_address;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    int pending;
    int failures;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;
    int hold_requests      = 0;
    int holds_served       = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    cubehelix_pixel_color_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_index  (pixel_index),
        .hue          (hue),
        .saturation   (saturation),
        .lightness    (lightness),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_address(pixel_address),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    chc_pixel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_index  (pixel_index),
        .hue          (hue),
        .saturation   (saturation),
        .lightness    (lightness),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_address(pixel_address),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pending      (pending),
        .failures     (failures)
    );

    // Watchdog: too many cycles without any transaction ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_cubehelix_pixel_color_top: FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    // Offer one pixel, with random idle cycles ahead of it; returns once accepted
    task automatic send_pixel(logic [15:0] idx, logic [15:0] h, logic [15:0] sat,
                              logic [15:0] lig);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_index <= idx;
        hue         <= h;
        saturation  <= sat;
        lightness   <= lig;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        logic [15:0] idx;
        logic [15:0] lig;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            lig = 16'($urandom_range(0, 32768));
        end
        else if (pick == 6)
        begin
            lig = 16'd32768;
        end
        else if (pick == 7)
        begin
            lig = 16'd0;
        end
        else
        begin
            lig = 16'($urandom);
        end
        idx = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2100)) : 16'($urandom);
        send_pixel(idx, 16'($urandom), 16'($urandom), lig);
    endtask

    // Stop offering and wait until every predicted result is back, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Write both segment registers; block must be idle
    task automatic write_segment(logic [10:0] offset_data, logic [10:0] length_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_OFFSET;
        cfg_data  <= offset_data;
        @(posedge clk);
        cfg_index <= CFG_STRIP_LENGTH;
        cfg_data  <= length_data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset segment, field extremes and the four quadrant boundaries
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd1023, 16'd43691, 16'd32768, 16'd16384);
        send_pixel(16'd1024, 16'd60075, 16'hFFFF, 16'd16384);
        send_pixel(16'd2047, 16'd10923, 16'hFFFF, 16'd16384);
        send_pixel(16'd1025, 16'd27307, 16'hFFFF, 16'd16384);
        // full-scale lightness saturates to 255
        send_pixel(16'd7, 16'd1234, 16'd32768, 16'd32768);
        send_pixel(16'd8, 16'd5000, 16'd0, 16'd32769);
        send_pixel(16'd9, 16'd0, 16'hFFFF, 16'd8192);
        send_pixel(16'd10, 16'd32768, 16'hFFFF, 16'd24576);
        send_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA);
        wait_drained();

        // Longest segment with top offset: address wraps past 2047
        write_segment(11'd1023, 11'd2047);
        send_pixel(16'd2046, 16'd100, 16'hFFFF, 16'd16384);
        send_pixel(16'hFFFF, 16'd49152, 16'd40000, 16'd20000);
        send_pixel(16'd2047, 16'd16384, 16'd65000, 16'd12000);
        wait_drained();

        // Zero length: every address is the offset
        write_segment(11'd5, 11'd0);
        send_pixel(16'd1234, 16'd300, 16'd30000, 16'd10000);
        send_pixel(16'd0, 16'd65535, 16'd65535, 16'd30000);
        wait_drained();

        // Random phases: each with its own segment setting and idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_segment(11'd1023, 11'd2047);
                1: write_segment(11'd0, 11'd1024);
                2: write_segment(11'd512, 11'd1);
                3: write_segment(11'($urandom), 11'($urandom));
                4: write_segment(11'd0, 11'd0);
                5: write_segment(11'h7FF, 11'd1024);
                6: write_segment(11'($urandom), 11'd3);
                default: write_segment(11'($urandom), 11'($urandom_range(1, 2047)));
            endcase
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 59;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 59;
                end
                default:
                begin
                    sender_idle_pct    = 15;
                    receiver_stall_pct = 15;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while the sender keeps offering
                if (p == 0 && n == 20)
                begin
                    hold_requests++;
                end
                send_random_pixel();
            end
            wait_drained();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        if (failures == 0 && pending == 0)
        begin
            $display("tb_cubehelix_pixel_color_top: PASS");
        end
        else
        begin
            $display("tb_cubehelix_pixel_color_top: FAIL");
        end
        $finish;
    end

endmodule
